@@ rtl/cbz_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared constants of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

  // x and y run through identical datapaths
  localparam int NUM_AXES   = 2;
  localparam int NUM_PTS    = 4;

  // slice width for the wide multiplies; each slice operand is at most 25 bits
  localparam int CHUNK_W    = 24;

  // register stages from input word to output register
  localparam int NUM_STAGES = 8;

endpackage

@@ rtl/cbz_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_if
// Valid/ready channels of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
interface cbz_in_if #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic        [T_FRAC_BITS:0]   param_t;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
    output ready
  );
endinterface

interface cbz_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

@@ rtl/cubic_bezier_point.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_point
// Evaluates a cubic Bezier curve at t by exact fixed-point de Casteljau steps.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one word per point: control points P0..P3 (signed, 4 fraction
//          bits) and param_t (unsigned Q1.T_FRAC_BITS, values above one act as one).
//   out_ch returns point_x / point_y, rounded to nearest (ties up), one word for
//          every input word, in order.
//   Output valid rises once the word has passed all eight register stages;
//   one word per cycle is taken and delivered when the
//   receiver keeps ready high. The eight register stages are three exact lerp
//   levels, each a multiply stage and a wide add stage, plus input and output
//   registers.
//   Each stage holds its word while the next one is full and stalled, and a
//   bubble anywhere lets the stages upstream of it move, so in_ch.ready stays
//   high while the output word waits as long as the pipe has room.
//   Reset (rst_n low, synchronous) empties all stages; payload is not cleared.
// ----------------------------------------------------------------------------
module cubic_bezier_point #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  cbz_in_if.sink   in_ch,
  cbz_out_if.source out_ch
);
  import cbz_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int TF  = T_FRAC_BITS;
  localparam int TW  = TF + 1;
  // each lerp level adds TF fraction bits; a convex blend never grows the range
  localparam int W1  = CW + TF;
  localparam int W2  = CW + 2 * TF;
  localparam int W3  = CW + 3 * TF;
  localparam int M1W = CW + TF + 3;
  localparam int D2W = W1 + 1;
  localparam int D3W = W2 + 1;
  localparam int NC2 = (D2W + CHUNK_W - 1) / CHUNK_W;
  localparam int NC3 = (D3W + CHUNK_W - 1) / CHUNK_W;
  localparam int X2W = NC2 * CHUNK_W;
  localparam int X3W = NC3 * CHUNK_W;
  localparam int PW  = CHUNK_W + TW + 2;
  localparam int WA2 = W2 + PW;
  localparam int WA3 = W3 + PW;
  localparam int K   = 3 * TF;

  localparam logic [TW-1:0]          T_ONE = TW'(1) << TF;
  localparam logic signed [WA3-1:0]  HALF  = WA3'(1) <<< (K - 1);

  // handshake along the stages
  logic [NUM_STAGES:0]   rdy;
  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;

  // stage 0: input register
  logic signed [CW-1:0] in_p     [NUM_AXES][NUM_PTS];
  logic signed [CW-1:0] s0_p_r   [NUM_AXES][NUM_PTS];
  logic [TW-1:0]        s0_t_nxt;
  logic [TW-1:0]        s0_t_r;

  // stage 1: first lerp products
  logic signed [TW:0]    tsg1;
  logic signed [CW:0]    d1       [NUM_AXES][NUM_PTS-1];
  logic signed [M1W-1:0] s1_m_nxt [NUM_AXES][NUM_PTS-1];
  logic signed [M1W-1:0] s1_m_r   [NUM_AXES][NUM_PTS-1];
  logic signed [CW-1:0]  s1_p_r   [NUM_AXES][NUM_PTS-1];
  logic [TW-1:0]         s1_t_r;

  // stage 2: first level points
  logic signed [M1W-1:0] acc1     [NUM_AXES][NUM_PTS-1];
  logic signed [W1-1:0]  s2_l_nxt [NUM_AXES][NUM_PTS-1];
  logic signed [W1-1:0]  s2_l_r   [NUM_AXES][NUM_PTS-1];
  logic [TW-1:0]         s2_t_r;

  // stage 3: second lerp slice products
  logic signed [TW:0]      tsg3;
  logic signed [D2W-1:0]   d2        [NUM_AXES][2];
  logic signed [X2W-1:0]   d2x       [NUM_AXES][2];
  logic signed [CHUNK_W:0] c2        [NUM_AXES][2][NC2];
  logic signed [PW-1:0]    s3_pp_nxt [NUM_AXES][2][NC2];
  logic signed [PW-1:0]    s3_pp_r   [NUM_AXES][2][NC2];
  logic signed [W1-1:0]    s3_l_r    [NUM_AXES][2];
  logic [TW-1:0]           s3_t_r;

  // stage 4: second level points
  logic signed [WA2-1:0] acc2     [NUM_AXES][2];
  logic signed [W2-1:0]  s4_l_nxt [NUM_AXES][2];
  logic signed [W2-1:0]  s4_l_r   [NUM_AXES][2];
  logic [TW-1:0]         s4_t_r;

  // stage 5: third lerp slice products
  logic signed [TW:0]      tsg5;
  logic signed [D3W-1:0]   d3        [NUM_AXES];
  logic signed [X3W-1:0]   d3x       [NUM_AXES];
  logic signed [CHUNK_W:0] c3        [NUM_AXES][NC3];
  logic signed [PW-1:0]    s5_pp_nxt [NUM_AXES][NC3];
  logic signed [PW-1:0]    s5_pp_r   [NUM_AXES][NC3];
  logic signed [W2-1:0]    s5_l_r    [NUM_AXES];

  // stage 6: curve point plus rounding half
  logic signed [WA3-1:0] acc3     [NUM_AXES];
  logic signed [W3-1:0]  s6_a_nxt [NUM_AXES];
  logic signed [W3-1:0]  s6_a_r   [NUM_AXES];

  // stage 7: output register
  logic signed [CW-1:0]  s7_pt_nxt [NUM_AXES];
  logic signed [CW-1:0]  s7_pt_r   [NUM_AXES];

  // --------------------------------------------------------------------------
  // Flow control
  // --------------------------------------------------------------------------
  always_comb begin
    rdy[NUM_STAGES] = out_ch.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_nxt       = {v_r[NUM_STAGES-2:0], in_ch.valid};
  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0
  // --------------------------------------------------------------------------
  always_comb begin
    in_p[0][0] = in_ch.p0_x;
    in_p[1][0] = in_ch.p0_y;
    in_p[0][1] = in_ch.p1_x;
    in_p[1][1] = in_ch.p1_y;
    in_p[0][2] = in_ch.p2_x;
    in_p[1][2] = in_ch.p2_y;
    in_p[0][3] = in_ch.p3_x;
    in_p[1][3] = in_ch.p3_y;
    s0_t_nxt   = (in_ch.param_t > T_ONE) ? T_ONE : in_ch.param_t;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_p_r <= in_p;
      s0_t_r <= s0_t_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: t * (P[i+1] - P[i])
  // --------------------------------------------------------------------------
  always_comb begin
    tsg1 = signed'({1'b0, s0_t_r});
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int i = 0; i < NUM_PTS - 1; i++) begin
        d1[ax][i]       = (CW + 1)'(s0_p_r[ax][i+1]) - (CW + 1)'(s0_p_r[ax][i]);
        s1_m_nxt[ax][i] = d1[ax][i] * tsg1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        for (int i = 0; i < NUM_PTS - 1; i++) begin
          s1_p_r[ax][i] <= s0_p_r[ax][i];
        end
      end
      s1_m_r <= s1_m_nxt;
      s1_t_r <= s0_t_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: L1 = P * ONE + product
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int i = 0; i < NUM_PTS - 1; i++) begin
        acc1[ax][i]     = (M1W'(s1_p_r[ax][i]) <<< TF) + s1_m_r[ax][i];
        s2_l_nxt[ax][i] = acc1[ax][i][W1-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_l_r <= s2_l_nxt;
      s2_t_r <= s1_t_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: difference sliced into CHUNK_W pieces, each times t
  // --------------------------------------------------------------------------
  always_comb begin
    tsg3 = signed'({1'b0, s2_t_r});
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int i = 0; i < 2; i++) begin
        d2[ax][i]  = D2W'(s2_l_r[ax][i+1]) - D2W'(s2_l_r[ax][i]);
        d2x[ax][i] = X2W'(d2[ax][i]);
        for (int k = 0; k < NC2; k++) begin
          // low slices are unsigned, the top slice carries the sign
          if (k == NC2 - 1) begin
            c2[ax][i][k] = signed'({d2x[ax][i][X2W-1], d2x[ax][i][k*CHUNK_W +: CHUNK_W]});
          end else begin
            c2[ax][i][k] = signed'({1'b0, d2x[ax][i][k*CHUNK_W +: CHUNK_W]});
          end
          s3_pp_nxt[ax][i][k] = c2[ax][i][k] * tsg3;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        for (int i = 0; i < 2; i++) begin
          s3_l_r[ax][i] <= s2_l_r[ax][i];
        end
      end
      s3_pp_r <= s3_pp_nxt;
      s3_t_r  <= s2_t_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: L2 = L1 * ONE + sum of slice products (modulo 2^WA2)
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      for (int i = 0; i < 2; i++) begin
        acc2[ax][i] = WA2'(s3_l_r[ax][i]) <<< TF;
        for (int k = 0; k < NC2; k++) begin
          acc2[ax][i] = acc2[ax][i] + (WA2'(s3_pp_r[ax][i][k]) <<< (CHUNK_W * k));
        end
        s4_l_nxt[ax][i] = acc2[ax][i][W2-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_l_r <= s4_l_nxt;
      s4_t_r <= s3_t_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: last difference sliced, each slice times t
  // --------------------------------------------------------------------------
  always_comb begin
    tsg5 = signed'({1'b0, s4_t_r});
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      d3[ax]  = D3W'(s4_l_r[ax][1]) - D3W'(s4_l_r[ax][0]);
      d3x[ax] = X3W'(d3[ax]);
      for (int k = 0; k < NC3; k++) begin
        if (k == NC3 - 1) begin
          c3[ax][k] = signed'({d3x[ax][X3W-1], d3x[ax][k*CHUNK_W +: CHUNK_W]});
        end else begin
          c3[ax][k] = signed'({1'b0, d3x[ax][k*CHUNK_W +: CHUNK_W]});
        end
        s5_pp_nxt[ax][k] = c3[ax][k] * tsg5;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
        s5_l_r[ax] <= s4_l_r[ax][0];
      end
      s5_pp_r <= s5_pp_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: L3 plus half an output LSB
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      acc3[ax] = (WA3'(s5_l_r[ax]) <<< TF) + HALF;
      for (int k = 0; k < NC3; k++) begin
        acc3[ax] = acc3[ax] + (WA3'(s5_pp_r[ax][k]) <<< (CHUNK_W * k));
      end
      s6_a_nxt[ax] = acc3[ax][W3-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_a_r <= s6_a_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: drop the 3*TF fraction bits (floor). The blend is convex, so the
  // rounded value always lies in the coordinate range and needs no clamp.
  // --------------------------------------------------------------------------
  always_comb begin
    for (int ax = 0; ax < NUM_AXES; ax++) begin
      s7_pt_nxt[ax] = s6_a_r[ax][W3-1:K];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_pt_r <= s7_pt_nxt;
    end
  end

  assign out_ch.valid   = v_r[NUM_STAGES-1];
  assign out_ch.point_x = s7_pt_r[0];
  assign out_ch.point_y = s7_pt_r[1];

endmodule

@@ rtl/cbz_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_checker
// Port-level checks of the cubic Bezier point evaluator, bound to its top.
// ----------------------------------------------------------------------------
module cbz_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_point_x,
  input logic [COORD_WIDTH-1:0] out_point_y
);
  import cbz_pkg::*;

  localparam int OCC_W = $clog2(NUM_STAGES + 1) + 1;

  // words accepted but not yet delivered
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;

  always_comb begin
    occ_nxt = occ_r + OCC_W'(in_valid && in_ready) - OCC_W'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) && $stable(out_point_y))
    else $error("output word changed while stalled");

  // a free output never blocks the input
  a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // no word comes out that was not taken in
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> occ_r != '0)
    else $error("output word without a pending input word");

  // never more words in flight than stages
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(NUM_STAGES))
    else $error("more words in flight than pipeline stages");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind cubic_bezier_point cbz_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_cbz_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_point_x(out_ch.point_x),
  .out_point_y(out_ch.point_y)
);

@@ verif/cbz_point_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbz_point_checker
// Passive scoreboard for cubic_bezier_point. It watches both channels. On every
// input word it computes the exact Bernstein blend of the four control points
// for each axis, then rounds and saturates the result, and queues that point.
// Every output word is compared field by field with the oldest queued point.
// ----------------------------------------------------------------------------
module cbz_point_checker #(
  parameter int COORD_WIDTH = 16,
  parameter int T_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  cbz_in_if    in_mon,
  cbz_out_if   out_mon,
  output int   fail_count,
  output int   pending
);

  localparam int BLEND_SHIFT = 3 * T_FRAC_BITS;
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } curve_pt_t;

  curve_pt_t expected_pts[$];
  int        n_errors  = 0;
  int        n_pending = 0;

  assign fail_count = n_errors;
  assign pending    = n_pending;

  // exact weighted sum at 3*T_FRAC_BITS fraction bits, round half up, clamp
  function automatic logic signed [COORD_WIDTH-1:0] bezier_axis(
    input logic signed [COORD_WIDTH-1:0] c0,
    input logic signed [COORD_WIDTH-1:0] c1,
    input logic signed [COORD_WIDTH-1:0] c2,
    input logic signed [COORD_WIDTH-1:0] c3,
    input logic        [T_FRAC_BITS:0]   t_raw
  );
    logic        [127:0] tw, sw, w0, w1, w2, w3;
    logic signed [127:0] acc, half, lim_hi, lim_lo;
    tw = (t_raw > T_ONE) ? T_ONE : t_raw;
    sw = T_ONE - tw;
    w0 = sw * sw * sw;
    w1 = 3 * tw * sw * sw;
    w2 = 3 * tw * tw * sw;
    w3 = tw * tw * tw;
    acc = c0 * $signed(w0) + c1 * $signed(w1) + c2 * $signed(w2) + c3 * $signed(w3);
    half = 1;
    half = half <<< (BLEND_SHIFT - 1);
    acc = (acc + half) >>> BLEND_SHIFT;
    lim_hi = 1;
    lim_hi = (lim_hi <<< (COORD_WIDTH - 1)) - 1;
    lim_lo = -lim_hi - 1;
    if (acc > lim_hi) acc = lim_hi;
    if (acc < lim_lo) acc = lim_lo;
    return acc[COORD_WIDTH-1:0];
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk) begin
    curve_pt_t pt;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        pt.x = bezier_axis(in_mon.p0_x, in_mon.p1_x, in_mon.p2_x, in_mon.p3_x,
                           in_mon.param_t);
        pt.y = bezier_axis(in_mon.p0_y, in_mon.p1_y, in_mon.p2_y, in_mon.p3_y,
                           in_mon.param_t);
        expected_pts.push_back(pt);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_pts.size() == 0) begin
          report_error($sformatf("output word (%0d, %0d) with nothing expected",
                                 out_mon.point_x, out_mon.point_y));
        end else begin
          pt = expected_pts.pop_front();
          if (out_mon.point_x !== pt.x)
            report_error($sformatf("point_x got %0d, want %0d", out_mon.point_x, pt.x));
          if (out_mon.point_y !== pt.y)
            report_error($sformatf("point_y got %0d, want %0d", out_mon.point_y, pt.y));
        end
      end
    end
    n_pending = expected_pts.size();
  end

endmodule

@@ verif/tb_cubic_bezier_point.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_point
// Stimulus and verdict for cubic_bezier_point. A short directed set covers the
// coordinate extremes, t at zero, one and above one, and halfway rounding
// ties. It is followed by random curves sent in bursts, while the receiver
// stalls on its own pattern. Checking is done by cbz_point_checker.
// ----------------------------------------------------------------------------
module tb_cubic_bezier_point;

  localparam int CW             = 16;
  localparam int TF             = 16;
  localparam int N_RANDOM       = 1350;
  localparam int DRAIN_CYCLES   = cbz_pkg::NUM_STAGES + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef struct {
    logic signed [CW-1:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
    logic        [TF:0]   param_t;
  } curve_word_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   burst_left  = 0;

  cbz_in_if  #(.COORD_WIDTH(CW), .T_FRAC_BITS(TF)) in_ch ();
  cbz_out_if #(.COORD_WIDTH(CW))                   out_ch ();

  cubic_bezier_point #(.COORD_WIDTH(CW), .T_FRAC_BITS(TF)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cbz_point_checker #(.COORD_WIDTH(CW), .T_FRAC_BITS(TF)) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic curve_word_t mk_curve(
    input logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy,
    input logic [TF:0] t
  );
    curve_word_t w;
    w.p0_x = ax; w.p0_y = ay; w.p1_x = bx; w.p1_y = by;
    w.p2_x = cx; w.p2_y = cy; w.p3_x = dx; w.p3_y = dy;
    w.param_t = t;
    return w;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return CW'($urandom);
    if (pick == 6) begin
      case ($urandom_range(0, 3))
        0: return C_MAX;
        1: return C_MIN;
        2: return '0;
        default: return '1;
      endcase
    end
    return CW'($signed($urandom_range(0, 511)) - 256);
  endfunction

  function automatic logic [TF:0] rand_t();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return (TF+1)'($urandom_range(0, T_ONE));
    if (pick < 15) return (TF+1)'($urandom_range(T_ONE + 1, {(TF+1){1'b1}}));  // above one
    if (pick < 17) return (TF+1)'($urandom_range(0, 255));
    if (pick < 19) return T_ONE - (TF+1)'($urandom_range(0, 255));
    return T_ONE >> 1;
  endfunction

  task automatic send_word(input curve_word_t w);
    in_ch.valid   <= 1'b1;
    in_ch.p0_x    <= w.p0_x;
    in_ch.p0_y    <= w.p0_y;
    in_ch.p1_x    <= w.p1_x;
    in_ch.p1_y    <= w.p1_y;
    in_ch.p2_x    <= w.p2_x;
    in_ch.p2_y    <= w.p2_y;
    in_ch.p3_x    <= w.p3_x;
    in_ch.p3_y    <= w.p3_y;
    in_ch.param_t <= w.param_t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // bursts of words separated by random gaps; long gap-free runs now and then
  task automatic push_curve(input curve_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    send_word(w);
    burst_left--;
  endtask

  // receiver: phases of always-ready, coin flip, sparse ready and long stalls
  initial begin
    int   mode;
    int   phase_left;
    int   hold_left;
    logic hold_lvl;
    mode       = 0;
    phase_left = 0;
    hold_left  = 0;
    hold_lvl   = 1'b1;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 3);
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_left == 0) begin
            hold_lvl  = ~hold_lvl;
            hold_left = hold_lvl ? $urandom_range(1, 6) : $urandom_range(1, 16);
          end
          hold_left--;
          out_ch.ready <= hold_lvl;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    curve_word_t directed[$];
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.p0_x    <= '0;
    in_ch.p0_y    <= '0;
    in_ch.p1_x    <= '0;
    in_ch.p1_y    <= '0;
    in_ch.p2_x    <= '0;
    in_ch.p2_y    <= '0;
    in_ch.p3_x    <= '0;
    in_ch.p3_y    <= '0;
    in_ch.param_t <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(mk_curve(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 0));
    directed.push_back(mk_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                T_ONE >> 1));
    directed.push_back(mk_curve(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
                                T_ONE));
    directed.push_back(mk_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                T_ONE >> 1));
    directed.push_back(mk_curve(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
                                T_ONE));
    directed.push_back(mk_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                T_ONE >> 1));
    directed.push_back(mk_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, 1));
    directed.push_back(mk_curve(C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
                                T_ONE - 1));
    directed.push_back(mk_curve(C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
                                T_ONE >> 2));
    // t above one acts as one
    directed.push_back(mk_curve(100, -200, 300, -400, 500, -600, C_MAX, C_MIN, T_ONE + 1));
    directed.push_back(mk_curve(100, -200, 300, -400, 500, -600, C_MIN, C_MAX, '1));
    directed.push_back(mk_curve(C_MAX, C_MIN, 7, -7, 9, -9, 0, 0, {1'b1, {TF{1'b1}}}));
    // halfway ties round toward plus infinity: +0.5 and -0.5 LSB at t = 1/2
    directed.push_back(mk_curve(4, -4, 0, 0, 0, 0, 0, 0, T_ONE >> 1));
    directed.push_back(mk_curve(-12, 12, 0, 0, 0, 0, 0, 0, T_ONE >> 1));
    directed.push_back(mk_curve(0, 0, 4, -4, 0, 0, 0, 0, T_ONE >> 1));
    directed.push_back(mk_curve(1, -1, 0, 0, 0, 0, 1, -1, T_ONE >> 1));
    directed.push_back(mk_curve(-1, 1, -1, 1, -1, 1, -1, 1, T_ONE >> 1));
    directed.push_back(mk_curve(C_MIN, C_MAX, 1, -1, -1, 1, C_MAX, C_MIN, 1));

    foreach (directed[i]) push_curve(directed[i]);

    repeat (N_RANDOM) begin
      push_curve(mk_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_t()));
    end
    in_ch.valid <= 1'b0;

    // let the checker queue the last word before polling pending
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
